FILE: rtl/rwlt_pkg.sv
// Shared types, codes and sizes for the reader/writer lock table.
package rwlt_pkg;

  localparam int TABLE_ENTRIES = 16;
  localparam int SLOT_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

  localparam logic [1:0] ACT_WRITE   = 2'd0;
  localparam logic [1:0] ACT_READ    = 2'd1;
  localparam logic [1:0] ACT_RELEASE = 2'd2;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_BUSY      = 3'd1;
  localparam logic [2:0] ST_FULL      = 3'd2;
  localparam logic [2:0] ST_NOT_HELD  = 3'd3;
  localparam logic [2:0] ST_SATURATED = 3'd4;

  localparam logic [7:0] READERS_MAX = 8'd255;

  typedef struct packed {
    logic [1:0]  action;
    logic [31:0] file_key;
    logic [31:0] client_key;
  } req_t;

  typedef struct packed {
    logic       granted;
    logic [2:0] status;
    logic [7:0] readers_now;
  } rsp_t;

  typedef struct packed {
    logic load;
    logic search;
    logic update;
  } cmd_t;

endpackage

FILE: rtl/rwlt_ctrl.sv
// Sequencing state machine for the reader/writer lock table.
module rwlt_ctrl
  import rwlt_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_ready,
  output logic rsp_valid,
  input  logic rsp_ready,
  output cmd_t cmd
);

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_SEARCH = 4'b0010,
    S_UPDATE = 4'b0100,
    S_HOLD   = 4'b1000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (req_valid) state_next = S_SEARCH;
      end
      S_SEARCH: state_next = S_UPDATE;
      S_UPDATE: state_next = S_HOLD;
      S_HOLD: begin
        if (rsp_ready) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  assign req_ready  = (state == S_IDLE);
  assign rsp_valid  = (state == S_HOLD);
  assign cmd.load   = (state == S_IDLE) && req_valid;
  assign cmd.search = (state == S_SEARCH);
  assign cmd.update = (state == S_UPDATE);

endmodule

FILE: rtl/rwlt_dp.sv
// Lock table storage, key search and update datapath.
module rwlt_dp
  import rwlt_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  cmd_t cmd,
  input  req_t req,
  output rsp_t rsp
);

  req_t req_q;
  rsp_t rsp_q;

  logic [TABLE_ENTRIES-1:0] slot_valid;
  logic [31:0]              slot_file    [TABLE_ENTRIES];
  logic                     slot_is_writer [TABLE_ENTRIES];
  logic [31:0]              slot_owner   [TABLE_ENTRIES];
  logic [7:0]               slot_readers [TABLE_ENTRIES];

  logic              hit_found, free_found;
  logic [SLOT_W-1:0] hit_idx, free_idx;
  logic              hit_found_next, free_found_next;
  logic [SLOT_W-1:0] hit_idx_next, free_idx_next;

  logic       hit_w;
  logic [7:0] hit_r;
  logic       hit_own;
  logic       ins_en, ins_writer, del_en, cnt_en;
  logic [7:0] cnt_value;
  rsp_t       rsp_next;

  always_ff @(posedge clk) begin
    if (cmd.load) req_q <= req;
  end

  always_comb begin
    hit_found_next  = 1'b0;
    free_found_next = 1'b0;
    hit_idx_next    = '0;
    free_idx_next   = '0;
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      if (!hit_found_next && slot_valid[i] && slot_file[i] == req_q.file_key) begin
        hit_found_next = 1'b1;
        hit_idx_next   = SLOT_W'(i);
      end
      if (!free_found_next && !slot_valid[i]) begin
        free_found_next = 1'b1;
        free_idx_next   = SLOT_W'(i);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.search) begin
      hit_found  <= hit_found_next;
      hit_idx    <= hit_idx_next;
      free_found <= free_found_next;
      free_idx   <= free_idx_next;
    end
  end

  assign hit_w   = slot_is_writer[hit_idx];
  assign hit_r   = slot_readers[hit_idx];
  assign hit_own = (slot_owner[hit_idx] == req_q.client_key);

  always_comb begin
    rsp_next   = '{granted: 1'b0, status: ST_OK, readers_now: 8'd0};
    ins_en     = 1'b0;
    ins_writer = 1'b0;
    del_en     = 1'b0;
    cnt_en     = 1'b0;
    cnt_value  = hit_r;
    case (req_q.action)
      ACT_WRITE: begin
        if (!hit_found) begin
          if (!free_found) begin
            rsp_next.status = ST_FULL;
          end else begin
            ins_en           = 1'b1;
            ins_writer       = 1'b1;
            rsp_next.granted = 1'b1;
          end
        end else if (hit_w && hit_own) begin
          rsp_next.granted = 1'b1;
        end else begin
          rsp_next.status      = ST_BUSY;
          rsp_next.readers_now = hit_w ? 8'd0 : hit_r;
        end
      end
      ACT_READ: begin
        if (!hit_found) begin
          if (!free_found) begin
            rsp_next.status = ST_FULL;
          end else begin
            ins_en               = 1'b1;
            rsp_next.granted     = 1'b1;
            rsp_next.readers_now = 8'd1;
          end
        end else if (hit_w) begin
          rsp_next.status = ST_BUSY;
        end else if (hit_r == READERS_MAX) begin
          rsp_next.status      = ST_SATURATED;
          rsp_next.readers_now = READERS_MAX;
        end else begin
          cnt_en               = 1'b1;
          cnt_value            = hit_r + 8'd1;
          rsp_next.granted     = 1'b1;
          rsp_next.readers_now = cnt_value;
        end
      end
      ACT_RELEASE: begin
        if (!hit_found) begin
          rsp_next.status = ST_NOT_HELD;
        end else if (hit_w || hit_r <= 8'd1) begin
          del_en           = 1'b1;
          rsp_next.granted = 1'b1;
        end else begin
          cnt_en               = 1'b1;
          cnt_value            = hit_r - 8'd1;
          rsp_next.granted     = 1'b1;
          rsp_next.readers_now = cnt_value;
        end
      end
      default: begin
        rsp_next = '{granted: 1'b0, status: ST_OK, readers_now: 8'd0};
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_valid <= '0;
    end else if (cmd.update) begin
      if (ins_en) slot_valid[free_idx] <= 1'b1;
      if (del_en) slot_valid[hit_idx] <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.update && ins_en) begin
      slot_file[free_idx]      <= req_q.file_key;
      slot_is_writer[free_idx] <= ins_writer;
      slot_owner[free_idx]     <= ins_writer ? req_q.client_key : 32'd0;
      slot_readers[free_idx]   <= ins_writer ? 8'd0 : 8'd1;
    end
    if (cmd.update && cnt_en) begin
      slot_readers[hit_idx] <= cnt_value;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.update) rsp_q <= rsp_next;
  end

  assign rsp = rsp_q;

  a_hit_still_valid: assert property (@(posedge clk) disable iff (rst)
    cmd.update && hit_found |-> slot_valid[hit_idx] && slot_file[hit_idx] == req_q.file_key)
    else $error("Matched slot changed between search and update.");

  a_no_free_means_full: assert property (@(posedge clk) disable iff (rst)
    cmd.update && !free_found |-> &slot_valid)
    else $error("Search reported no free slot while one was free.");

  a_insert_only_on_miss: assert property (@(posedge clk) disable iff (rst)
    cmd.update && ins_en |-> !hit_found && !slot_valid[free_idx])
    else $error("Insert would overwrite a live slot or duplicate a key.");

  a_single_table_op: assert property (@(posedge clk) disable iff (rst)
    cmd.update |-> $countones({ins_en, del_en, cnt_en}) <= 1)
    else $error("More than one table operation in one update.");

endmodule

FILE: rtl/reader_writer_lock_table.sv
// Top level of the reader/writer lock table.
//
//   Channel  Signals                        Moves
//   req      req_valid, req_ready, req      action, file key, client key
//   rsp      rsp_valid, rsp_ready, rsp      granted, status, reader count
//
// The request is registered at its transfer. The search state then registers
// the parallel key and free-slot search over all slots, and the update state
// updates the table and loads the response register, which is valid in the
// hold state. A new request is accepted only in the idle state. Synchronous
// reset clears all slot valid bits at once. A stalled response holds the block
// until it is taken; no new request is accepted meanwhile.
module reader_writer_lock_table
  import rwlt_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_ready,
  input  req_t req,
  output logic rsp_valid,
  input  logic rsp_ready,
  output rsp_t rsp
);

  cmd_t cmd;

  rwlt_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .cmd       (cmd)
  );

  rwlt_dp u_dp (
    .clk (clk),
    .rst (rst),
    .cmd (cmd),
    .req (req),
    .rsp (rsp)
  );

endmodule

FILE: tb/sv/tb_top.sv
// Self-checking testbench for the reader/writer lock table with a driver, a monitor and a predictor.
module tb_top;
  import rwlt_pkg::*;

  localparam logic [1:0] ACT_UNUSED = 2'd3;
  localparam int LIMIT_CYCLES = 400000;
  localparam int TAIL_CYCLES = 20;
  localparam int RANDOM_ITEMS = 500;
  localparam int POOL_FILES = 24;
  localparam int POOL_CLIENTS = 4;

  typedef struct {
    req_t req;
    bit   wait_idle;
  } pending_req_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_ready;
  req_t req = '0;
  logic rsp_valid;
  logic rsp_ready = 1'b0;
  rsp_t rsp;

  pending_req_t pending_reqs[$];
  rsp_t lock_outcomes[$];

  logic        tbl_valid[TABLE_ENTRIES];
  logic [31:0] tbl_file[TABLE_ENTRIES];
  logic        tbl_writer[TABLE_ENTRIES];
  logic [31:0] tbl_owner[TABLE_ENTRIES];
  logic [7:0]  tbl_readers[TABLE_ENTRIES];

  int issued_cnt = 0;
  int accepted_cnt = 0;
  int cycle_cnt = 0;
  int error_cnt = 0;
  int burst_left = 0;
  int gap_left = 0;
  int rsp_hold = 0;
  int rsp_mode = 0;
  int mode_left = 0;

  reader_writer_lock_table dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

  always #4 clk = ~clk;

  function automatic rsp_t apply_lock_request(req_t r);
    rsp_t o;
    int hit;
    int free_slot;
    o = '0;
    o.status = ST_OK;
    hit = -1;
    free_slot = -1;
    for (int i = TABLE_ENTRIES - 1; i >= 0; i--) begin
      if (tbl_valid[i] && tbl_file[i] == r.file_key) hit = i;
      if (!tbl_valid[i]) free_slot = i;
    end
    case (r.action)
      ACT_WRITE: begin
        if (hit < 0) begin
          if (free_slot < 0) begin
            o.status = ST_FULL;
          end else begin
            tbl_valid[free_slot] = 1'b1;
            tbl_file[free_slot] = r.file_key;
            tbl_writer[free_slot] = 1'b1;
            tbl_owner[free_slot] = r.client_key;
            tbl_readers[free_slot] = 8'd0;
            o.granted = 1'b1;
          end
        end else if (tbl_writer[hit] && tbl_owner[hit] == r.client_key) begin
          o.granted = 1'b1;
        end else begin
          o.status = ST_BUSY;
          o.readers_now = tbl_writer[hit] ? 8'd0 : tbl_readers[hit];
        end
      end
      ACT_READ: begin
        if (hit < 0) begin
          if (free_slot < 0) begin
            o.status = ST_FULL;
          end else begin
            tbl_valid[free_slot] = 1'b1;
            tbl_file[free_slot] = r.file_key;
            tbl_writer[free_slot] = 1'b0;
            tbl_owner[free_slot] = '0;
            tbl_readers[free_slot] = 8'd1;
            o.granted = 1'b1;
            o.readers_now = 8'd1;
          end
        end else if (tbl_writer[hit]) begin
          o.status = ST_BUSY;
        end else if (tbl_readers[hit] == READERS_MAX) begin
          o.status = ST_SATURATED;
          o.readers_now = READERS_MAX;
        end else begin
          tbl_readers[hit] = tbl_readers[hit] + 8'd1;
          o.granted = 1'b1;
          o.readers_now = tbl_readers[hit];
        end
      end
      ACT_RELEASE: begin
        if (hit < 0) begin
          o.status = ST_NOT_HELD;
        end else if (tbl_writer[hit] || tbl_readers[hit] <= 8'd1) begin
          tbl_valid[hit] = 1'b0;
          o.granted = 1'b1;
        end else begin
          tbl_readers[hit] = tbl_readers[hit] - 8'd1;
          o.granted = 1'b1;
          o.readers_now = tbl_readers[hit];
        end
      end
      default: begin
      end
    endcase
    return o;
  endfunction

  task automatic add_req(logic [1:0] action, logic [31:0] file_key, logic [31:0] client_key,
                         bit wait_idle);
    pending_req_t p;
    p.req.action = action;
    p.req.file_key = file_key;
    p.req.client_key = client_key;
    p.wait_idle = wait_idle;
    pending_reqs.push_back(p);
  endtask

  // Driver: bursts of transfers separated by random gaps.
  always @(negedge clk) begin
    pending_req_t item;
    logic next_valid;
    if (rst) begin
      req_valid <= 1'b0;
    end else if (issued_cnt == accepted_cnt) begin
      next_valid = 1'b0;
      if (gap_left > 0) begin
        gap_left--;
      end else if (pending_reqs.size() > 0 &&
                   !(pending_reqs[0].wait_idle && lock_outcomes.size() != 0)) begin
        item = pending_reqs.pop_front();
        req <= item.req;
        next_valid = 1'b1;
        issued_cnt++;
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(0, 30);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
        end
      end
      req_valid <= next_valid;
    end
  end

  // Receiver: stall pattern that switches between modes.
  always @(negedge clk) begin
    if (mode_left == 0) begin
      rsp_mode = $urandom_range(0, 2);
      mode_left = $urandom_range(50, 400);
    end else begin
      mode_left--;
    end
    if (rsp_hold > 0) begin
      rsp_ready <= 1'b0;
      rsp_hold--;
    end else begin
      rsp_ready <= 1'b1;
      case (rsp_mode)
        1: if ($urandom_range(0, 3) == 0) rsp_hold = $urandom_range(1, 3);
        2: if ($urandom_range(0, 9) == 0) rsp_hold = $urandom_range(5, 20);
        default: begin
        end
      endcase
    end
  end

  // Monitor: predict on each request transfer, check each response transfer.
  always @(posedge clk) begin
    rsp_t want;
    cycle_cnt++;
    if (!rst && req_valid && req_ready) begin
      accepted_cnt++;
      lock_outcomes.push_back(apply_lock_request(req));
    end
    if (!rst && rsp_valid && rsp_ready) begin
      if (lock_outcomes.size() == 0) begin
        error_cnt++;
        if (error_cnt <= 10)
          $display("unexpected response: granted %0d status %0d readers %0d",
                   rsp.granted, rsp.status, rsp.readers_now);
      end else begin
        want = lock_outcomes.pop_front();
        if (rsp.granted !== want.granted || rsp.status !== want.status ||
            rsp.readers_now !== want.readers_now) begin
          error_cnt++;
          if (error_cnt <= 10)
            $display("mismatch: expected granted %0d status %0d readers %0d, got %0d %0d %0d",
                     want.granted, want.status, want.readers_now,
                     rsp.granted, rsp.status, rsp.readers_now);
        end
      end
    end
  end

  initial begin
    logic [31:0] file_pool[POOL_FILES];
    logic [31:0] client_pool[POOL_CLIENTS];
    logic [31:0] fill_keys[TABLE_ENTRIES - 1];
    logic [31:0] sat_key;
    logic [31:0] fk;
    logic [31:0] ck;
    logic [1:0] act;
    int pick;

    for (int i = 0; i < TABLE_ENTRIES; i++) tbl_valid[i] = 1'b0;

    add_req(ACT_WRITE, 32'h0, 32'h0, 1'b0);
    add_req(ACT_WRITE, 32'h0, 32'h0, 1'b0);
    add_req(ACT_WRITE, 32'h0, 32'hFFFF_FFFF, 1'b0);
    add_req(ACT_READ, 32'h0, 32'h0, 1'b0);
    add_req(ACT_RELEASE, 32'h0, 32'hFFFF_FFFF, 1'b0);
    add_req(ACT_READ, 32'hFFFF_FFFF, 32'h0, 1'b0);
    add_req(ACT_READ, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
    add_req(ACT_WRITE, 32'hFFFF_FFFF, 32'h5, 1'b0);
    add_req(ACT_RELEASE, 32'hFFFF_FFFF, 32'h0, 1'b0);
    add_req(ACT_RELEASE, 32'hFFFF_FFFF, 32'h0, 1'b0);
    add_req(ACT_RELEASE, 32'hFFFF_FFFF, 32'h0, 1'b0);
    add_req(ACT_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
    add_req(ACT_RELEASE, 32'h0, 32'h0, 1'b0);

    // Drive one file to the reader limit, then fill every remaining slot.
    sat_key = $urandom() | 32'h1;
    for (int i = 0; i < 256; i++) add_req(ACT_READ, sat_key, $urandom(), i == 0);
    add_req(ACT_WRITE, sat_key, $urandom(), 1'b0);
    for (int i = 0; i < TABLE_ENTRIES - 1; i++) begin
      fill_keys[i] = {sat_key[31:8] ^ 24'hA5A5A5, 8'(i)};
      add_req((i % 2 == 0) ? ACT_WRITE : ACT_READ, fill_keys[i], $urandom(), 1'b0);
    end
    add_req(ACT_WRITE, ~sat_key, $urandom(), 1'b0);
    add_req(ACT_READ, ~sat_key, $urandom(), 1'b0);
    add_req(ACT_READ, sat_key, $urandom(), 1'b0);
    add_req(ACT_RELEASE, sat_key, $urandom(), 1'b0);
    add_req(ACT_READ, sat_key, $urandom(), 1'b0);
    for (int i = 0; i < TABLE_ENTRIES - 1; i++) add_req(ACT_RELEASE, fill_keys[i], $urandom(), 1'b0);

    file_pool[0] = 32'h0;
    file_pool[1] = 32'hFFFF_FFFF;
    file_pool[2] = sat_key;
    for (int i = 3; i < POOL_FILES; i++) file_pool[i] = $urandom();
    client_pool[0] = 32'h0;
    client_pool[1] = 32'hFFFF_FFFF;
    for (int i = 2; i < POOL_CLIENTS; i++) client_pool[i] = $urandom();

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      pick = $urandom_range(0, 99);
      act = (pick < 36) ? ACT_WRITE : (pick < 70) ? ACT_READ :
            (pick < 97) ? ACT_RELEASE : ACT_UNUSED;
      fk = ($urandom_range(0, 9) == 0) ? $urandom() : file_pool[$urandom_range(0, POOL_FILES - 1)];
      ck = ($urandom_range(0, 6) == 0) ? $urandom() :
           client_pool[$urandom_range(0, POOL_CLIENTS - 1)];
      add_req(act, fk, ck, (n % 200) == 0);
    end

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while ((pending_reqs.size() > 0 || issued_cnt != accepted_cnt || lock_outcomes.size() > 0)
           && cycle_cnt < LIMIT_CYCLES)
      @(posedge clk);
    if (cycle_cnt < LIMIT_CYCLES) repeat (TAIL_CYCLES) @(posedge clk);
    else $display("timeout after %0d cycles", cycle_cnt);

    if (cycle_cnt < LIMIT_CYCLES && error_cnt == 0 && lock_outcomes.size() == 0) begin
      $display("** reader_writer_lock_table: PASSED **");
    end else begin
      $display("** reader_writer_lock_table: FAILED **");
    end
    $finish;
  end

endmodule

FILE: files.f
rtl/rwlt_pkg.sv
rtl/rwlt_ctrl.sv
rtl/rwlt_dp.sv
rtl/reader_writer_lock_table.sv
tb/sv/tb_top.sv
